// File: rtl/core/smld_pkg.sv
// Shared types, constants and register codes for the sync marker length deframer.
package smld_pkg;

    localparam int MARKER_BYTES = 4;
    localparam int MARKER_W = MARKER_BYTES * 8;
    localparam int RECENT_W = (MARKER_BYTES > 1) ? (MARKER_BYTES - 1) * 8 : 8;
    localparam int CMP_W = (MARKER_W > 32) ? MARKER_W : 32;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARKER_WORD = 2'd0,
        CFG_HEADER_SKIP = 2'd1,
        CFG_MIN_LENGTH  = 2'd2
    } cfg_index_t;

    localparam logic [31:0] MARKER_WORD_RESET = 32'h4954_5300;
    localparam logic [3:0]  HEADER_SKIP_RESET = 4'd4;
    localparam logic [7:0]  MIN_LENGTH_RESET  = 8'd14;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SKIP = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [31:0] marker_word;
        logic [3:0]  header_skip;
        logic [7:0]  min_length;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       first_byte;
        logic       last_byte;
        logic       aborted;
    } result_t;

endpackage

// File: rtl/core/sync_marker_length_deframer_unit.sv
// Top level of the sync marker length deframer with its result register.
//
//   Channel  Direction  Payload
//   s_       in         tdata = rx_byte
//   m_       out        tdata = out_byte, tlast = last_byte, tuser = first_byte, aborted
//   cfg_     in         index and 32-bit data for register writes
//
// Each request passes combinationally through the marker compare and frame sequencer into the result register.
// A new request can be accepted every cycle; the result register holds at most one result.
// The input side stalls only while a result is held and the output side is not ready.
// Synchronous active-low reset returns to marker hunting with the default registers.
module sync_marker_length_deframer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,
    output logic [1:0]                     m_tuser,   // [0] first_byte, [1] aborted
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import smld_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    step;
    logic    hit;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic [1:0] m_user_reg;

    assign cfg_ready = 1'b1;
    assign s_tready = !m_valid_reg || m_tready;
    assign step = s_tvalid && s_tready;

    smld_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smld_marker_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (s_tdata),
        .marker_word (cfg.marker_word),
        .hit         (hit)
    );

    smld_frame_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .hit     (hit),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = result.valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            m_data_reg <= result.out_byte;
            m_last_reg <= result.last_byte;
            m_user_reg <= {result.aborted, result.first_byte};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;
    assign m_tuser = m_user_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("Abort result without last flag.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == 8'd0) && !m_tuser[0])
        else $error("Abort result carries payload or first flag.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Request accepted while result register is blocked.");
`endif

endmodule

// File: rtl/core/smld_cfg_regs.sv
// Configuration register bank for the deframer.
module smld_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [smld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output smld_pkg::cfg_t                 cfg
);
    import smld_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_MARKER_WORD: cfg_next.marker_word = cfg_data;
                CFG_HEADER_SKIP: cfg_next.header_skip = cfg_data[3:0];
                CFG_MIN_LENGTH:  cfg_next.min_length = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.marker_word <= MARKER_WORD_RESET;
            cfg_reg.header_skip <= HEADER_SKIP_RESET;
            cfg_reg.min_length <= MIN_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/smld_marker_match.sv
// Byte history and marker comparison over the most recent received bytes.
module smld_marker_match (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] marker_word,
    output logic        hit
);
    import smld_pkg::*;

    logic [RECENT_W-1:0] recent_reg;
    logic [RECENT_W-1:0] recent_next;
    logic [MARKER_W-1:0] window;

    assign window = MARKER_W'({recent_reg, rx_byte});
    assign hit = (CMP_W'(window) == CMP_W'(MARKER_W'(marker_word)));
    assign recent_next = step ? RECENT_W'(window) : recent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
        end else begin
            recent_reg <= recent_next;
        end
    end

endmodule

// File: rtl/core/smld_frame_fsm.sv
// Frame sequencer: header skip, length check and payload result formation.
module smld_frame_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              hit,
    input  logic [7:0]        rx_byte,
    input  smld_pkg::cfg_t    cfg,
    output smld_pkg::result_t result
);
    import smld_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  skip_reg;
    logic [3:0]  skip_next;
    logic [7:0]  left_reg;
    logic [7:0]  left_next;
    logic        start_reg;
    logic        start_next;
    logic [3:0]  skip_dec;
    logic [7:0]  left_dec;

    assign skip_dec = skip_reg - 4'd1;
    assign left_dec = left_reg - 8'd1;

    always_comb begin
        phase_next = phase_reg;
        skip_next = skip_reg;
        left_next = left_reg;
        start_next = start_reg;
        if (step) begin
            if (hit) begin
                skip_next = cfg.header_skip;
                left_next = '0;
                start_next = 1'b0;
                phase_next = (cfg.header_skip == 4'd0) ? PH_LEN : PH_SKIP;
            end else begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        phase_next = PH_HUNT;
                    end
                    PH_SKIP: begin
                        skip_next = skip_dec;
                        if (skip_dec == 4'd0) begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (rx_byte == 8'd0 || rx_byte < cfg.min_length) begin
                            phase_next = PH_HUNT;
                            left_next = '0;
                            start_next = 1'b0;
                        end else begin
                            phase_next = PH_DATA;
                            left_next = rx_byte;
                            start_next = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        start_next = 1'b0;
                        left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default: phase_next = PH_HUNT;
                endcase
            end
        end
    end

    always_comb begin
        result.valid = (phase_reg == PH_DATA);
        if (hit) begin
            result.out_byte = '0;
            result.first_byte = 1'b0;
            result.last_byte = 1'b1;
            result.aborted = 1'b1;
        end else begin
            result.out_byte = rx_byte;
            result.first_byte = start_reg;
            result.last_byte = (left_reg == 8'd1);
            result.aborted = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            skip_reg <= '0;
            left_reg <= '0;
            start_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            skip_reg <= skip_next;
            left_reg <= left_next;
            start_reg <= start_next;
        end
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the sync marker length deframer with randomized flow control.
module tb_top;
    import smld_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_SETTING = 60;
    localparam logic [CMP_W-1:0] MARK_MASK = {CMP_W{1'b1}} >> (CMP_W - MARKER_W);

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_MARKER_WORD;
    logic [31:0] cfg_data = 32'h0;

    logic [7:0] rx_q[$];
    result_t    frame_out_q[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_cnt = 0;
    int         quiet_cycles = 0;
    int         chunk_items = 0;

    logic [31:0]         mk_word = MARKER_WORD_RESET;
    logic [3:0]          hdr_skip = HEADER_SKIP_RESET;
    logic [7:0]          min_len = MIN_LENGTH_RESET;
    logic [RECENT_W-1:0] hist = '0;
    phase_t              ph = PH_HUNT;
    logic [3:0]          skip_left = '0;
    logic [7:0]          left = '0;
    logic                first_pend = 1'b0;

    sync_marker_length_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic deframe_byte(input logic [7:0] b);
        logic [MARKER_W-1:0] win;
        logic                hit;
        result_t             r;
        win = MARKER_W'({hist, b});
        hit = (CMP_W'(win) == (CMP_W'(mk_word) & MARK_MASK));
        hist = RECENT_W'(win);
        r = '0;
        r.valid = 1'b1;
        if (hit) begin
            if (ph == PH_DATA) begin
                r.last_byte = 1'b1;
                r.aborted = 1'b1;
                frame_out_q = {frame_out_q, r};
            end
            left = '0;
            first_pend = 1'b0;
            skip_left = hdr_skip;
            ph = (hdr_skip == 4'd0) ? PH_LEN : PH_SKIP;
        end else begin
            case (ph)
                PH_SKIP: begin
                    skip_left = skip_left - 4'd1;
                    if (skip_left == 4'd0) ph = PH_LEN;
                end
                PH_LEN: begin
                    if (b == 8'd0 || b < min_len) begin
                        ph = PH_HUNT;
                        left = '0;
                        first_pend = 1'b0;
                    end else begin
                        left = b;
                        first_pend = 1'b1;
                        ph = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r.out_byte = b;
                    r.first_byte = first_pend;
                    r.last_byte = (left == 8'd1);
                    frame_out_q = {frame_out_q, r};
                    first_pend = 1'b0;
                    left = left - 8'd1;
                    if (left == 8'd0) ph = PH_HUNT;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= rx_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_out_q.size() == 0) begin
                    $error("result with no request pending: byte 0x%02h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = frame_out_q.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata);
                    check_field("first_byte", 8'(want.first_byte), 8'(m_tuser[0]));
                    check_field("last_byte", 8'(want.last_byte), 8'(m_tlast));
                    check_field("aborted", 8'(want.aborted), 8'(m_tuser[1]));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MARKER_WORD: mk_word = value;
            CFG_HEADER_SKIP: hdr_skip = value[3:0];
            CFG_MIN_LENGTH:  min_len = value[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_settings(input logic [31:0] mw, input logic [3:0] sk,
                                 input logic [7:0] ml);
        put_reg(CFG_MARKER_WORD, mw);
        put_reg(CFG_HEADER_SKIP, {28'h0, sk});
        put_reg(CFG_MIN_LENGTH, {24'h0, ml});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (rx_q.size() != 0 || s_tvalid || frame_out_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_q = {rx_q, b};
        chunk_items++;
    endtask

    task automatic push_marker(input int count);
        logic [CMP_W-1:0] mw;
        mw = CMP_W'(mk_word);
        for (int i = MARKER_BYTES - 1; i >= MARKER_BYTES - count; i--) push_byte(mw[i*8 +: 8]);
    endtask

    task automatic push_random_chunk();
        int kind;
        int lo;
        int hi;
        int len;
        int cut;
        kind = $urandom_range(99);
        if (kind < 60) begin
            push_marker(MARKER_BYTES);
            repeat (hdr_skip) push_byte(8'($urandom));
            lo = (min_len == 8'd0) ? 1 : min_len;
            hi = (lo + 12 > 255) ? 255 : lo + 12;
            len = $urandom_range(hi, lo);
            push_byte(8'(len));
            cut = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == cut) begin
                    push_marker(MARKER_BYTES);
                    break;
                end
                push_byte(8'($urandom));
            end
        end else if (kind < 75) begin
            push_marker(MARKER_BYTES);
            repeat (hdr_skip) push_byte(8'($urandom));
            push_byte((min_len <= 8'd1) ? 8'd0 : 8'($urandom_range(min_len - 1)));
        end else if (kind < 88) begin
            push_marker(MARKER_BYTES);
            repeat ($urandom_range(hdr_skip)) push_byte(8'($urandom));
        end else begin
            if ($urandom_range(1)) push_marker($urandom_range(MARKER_BYTES - 1, 1));
            repeat ($urandom_range(8, 1)) push_byte(8'($urandom));
        end
    endtask

    initial begin
        logic [31:0] mw;
        logic [3:0]  sk;
        logic [7:0]  ml;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 70;
        load_settings(MARKER_WORD_RESET, 4'd0, 8'd2);
        push_marker(MARKER_BYTES);
        push_byte(8'h00);
        push_marker(MARKER_BYTES);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_marker(MARKER_BYTES);
        push_byte(8'h05);
        push_marker(MARKER_BYTES);
        push_byte(8'h04);
        push_marker(MARKER_BYTES);
        push_byte(8'h01);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin mw = 32'h4954_5300; sk = 4'd4;  ml = 8'd14;  end
                1: begin mw = 32'hFFFF_FFFF; sk = 4'd15; ml = 8'd1;   end
                2: begin mw = 32'hA55A_0FF0; sk = 4'd0;  ml = 8'd255; end
                3: begin mw = 32'h0000_0000; sk = 4'd1;  ml = 8'd3;   end
                4: begin mw = 32'h7E7E_7E7E; sk = 4'd2;  ml = 8'd1;   end
                5: begin mw = 32'h1234_5678; sk = 4'd15; ml = 8'd8;   end
                6: begin mw = 32'h8000_0001; sk = 4'd0;  ml = 8'd2;   end
                7: begin mw = 32'hC3C3_3C3C; sk = 4'd7;  ml = 8'd20;  end
                default: begin
                    mw = $urandom;
                    sk = 4'($urandom_range(15));
                    ml = 8'($urandom_range(40, 1));
                end
            endcase
            if (p < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 70;
            end else if (p < 6) begin
                send_idle_pct = 70;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_settings(mw, sk, ml);
            chunk_items = 0;
            while (chunk_items < ITEMS_PER_SETTING) push_random_chunk();
            wait_drained();
        end

        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
